### design/pcfm_pkg.sv
// ----------------------------------------------------------------------------
// pcfm_pkg
// shared types and constants of the period capture frequency meter
// ----------------------------------------------------------------------------
package pcfm_pkg;

	localparam int CLK_W       = 26;  // timer clock register and frequency width
	localparam int CAP_IN_W    = 16;  // capture_value and period_ticks field width
	localparam int CAPTURE_DEF = 16;  // default timer width
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 48;
	localparam int ADDR_W      = 3;

	localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(1000000);

	localparam logic [1:0] CMD_CAPTURE = 2'd0;
	localparam logic [1:0] CMD_TIMEOUT = 2'd1;
	localparam logic [1:0] CMD_ACK     = 2'd2;

	localparam logic REG_TIMER_CLOCK = 1'b0;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PUSH
	} state_t;

endpackage

### design/pcfm_div.sv
// ----------------------------------------------------------------------------
// pcfm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pcfm_div #(
	parameter int DIVIDEND_W = pcfm_pkg::CLK_W,
	parameter int DIVISOR_W  = pcfm_pkg::CAPTURE_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  busy,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);
	import pcfm_pkg::*;

	localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// shift the next dividend bit into the partial remainder and try a subtract
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### design/period_capture_frequency_meter.sv
// ----------------------------------------------------------------------------
// period_capture_frequency_meter
// reciprocal frequency meter working on pairs of capture timestamps
// ----------------------------------------------------------------------------
// Each command item is taken on the slave stream and answered by exactly one
// status item on the master stream (period, latched frequency, updated flag).
// A timeout or acknowledge command, a first capture and a second capture that
// needs no division pass through the push state to the output register. A
// second capture that latches a new frequency from a nonzero period waits in
// the divide state for the restoring divider, one quotient bit per cycle.
// The slave side is not ready while an item is in work; a result that waits
// for the master side holds the block in its output stage.
module period_capture_frequency_meter #(
	parameter int CAPTURE_WIDTH = pcfm_pkg::CAPTURE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// apb configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [pcfm_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// command stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pcfm_pkg::IN_DATA_W-1:0] s_tdata,   // cmd[1:0], capture_value[17:2]
	// status stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pcfm_pkg::OUT_DATA_W-1:0] m_tdata   // period_ticks[15:0],
	                                                  // frequency_hz[41:16],
	                                                  // freq_updated[42]
);
	import pcfm_pkg::*;

	state_t state_q, state_d;

	logic [CLK_W-1:0]         timer_clock_q;
	logic                     second_edge_q;
	logic [CAPTURE_WIDTH-1:0] first_ts_q;
	logic                     timed_out_q;
	logic [CAPTURE_WIDTH-1:0] period_q;
	logic [CLK_W-1:0]         freq_q;
	logic                     updated_q;

	logic                     m_tvalid_q;
	logic [CAP_IN_W-1:0]      out_period_q;
	logic [CLK_W-1:0]         out_freq_q;
	logic                     out_updated_q;

	logic [1:0]               cmd;
	logic [CAP_IN_W-1:0]      cap_in;
	logic [CAPTURE_WIDTH-1:0] cap;
	logic [CAPTURE_WIDTH-1:0] diff;
	logic [CAP_IN_W-1:0]      period_out;
	logic                     s_acc;
	logic                     out_free;
	logic                     div_start;
	logic                     div_busy;
	logic                     div_done;
	logic [CLK_W-1:0]         div_quot;
	logic                     cfg_wr;

	assign cmd    = s_tdata[1:0];
	assign cap_in = s_tdata[CAP_IN_W+1:2];

	generate
		if (CAPTURE_WIDTH >= CAP_IN_W) begin : g_wide
			assign cap        = CAPTURE_WIDTH'(cap_in);
			assign period_out = period_q[CAP_IN_W-1:0];
		end else begin : g_narrow
			assign cap        = cap_in[CAPTURE_WIDTH-1:0];
			assign period_out = CAP_IN_W'(period_q);
		end
	endgenerate

	// wrapped period modulo the timer width
	assign diff     = cap - first_ts_q;
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign div_start = s_acc && (cmd == CMD_CAPTURE) && second_edge_q && !timed_out_q
		&& !updated_q && (diff != '0);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TIMER_CLOCK);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_TIMER_CLOCK) begin
			prdata = 32'(timer_clock_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_clock_q <= CLK_RESET;
		end else if (cfg_wr) begin
			timer_clock_q <= pwdata[CLK_W-1:0];
		end
	end

	pcfm_div #(
		.DIVIDEND_W (CLK_W),
		.DIVISOR_W  (CAPTURE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (timer_clock_q),
		.divisor  (diff),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quot)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = div_start ? ST_DIV : ST_PUSH;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_edge_q <= 1'b0;
			first_ts_q    <= '0;
			timed_out_q   <= 1'b0;
			period_q      <= '0;
			freq_q        <= '0;
			updated_q     <= 1'b0;
		end else if (s_acc) begin
			case (cmd)
				CMD_CAPTURE: begin
					if (!second_edge_q) begin
						first_ts_q    <= cap;
						second_edge_q <= 1'b1;
						timed_out_q   <= 1'b0;
					end else begin
						second_edge_q <= 1'b0;
						if (!timed_out_q) begin
							period_q <= diff;
							// with no update pending, zero period latches frequency 0 and nonzero waits for the divider
							if (!updated_q && (diff == '0)) begin
								freq_q    <= '0;
								updated_q <= 1'b1;
							end
						end else begin
							timed_out_q <= 1'b0;
							if (!updated_q) begin
								freq_q    <= '0;
								updated_q <= 1'b1;
							end
						end
					end
				end
				CMD_TIMEOUT: timed_out_q <= 1'b1;
				CMD_ACK:     updated_q   <= 1'b0;
				default: ;
			endcase
		end else if ((state_q == ST_DIV) && div_done) begin
			freq_q    <= div_quot;
			updated_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_PUSH) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_PUSH) && out_free) begin
			out_period_q  <= period_out;
			out_freq_q    <= freq_q;
			out_updated_q <= updated_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - CAP_IN_W - CLK_W - 1){1'b0}},
		out_updated_q, out_freq_q, out_period_q};

`ifndef SYNTHESIS
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !div_busy)
		else $error("command taken while the divider is running");

	a_div_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_busy || div_done))
		else $error("waiting on a divider that is not running");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == ST_DIV))
		else $error("divider started without entering the divide state");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |=> (m_tvalid_q && $stable(m_tdata)))
		else $error("pending result lost before transfer");
`endif

endmodule
